/* design/circular_list_deque_with_search_assert.svh */
// Assertion macros shared by the checker of the deque block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CIRCULAR_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cldq_pkg.sv */
// Shared constants and types of the circular deque with search.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package cldq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MODE_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STS_W     = 2;
  localparam int POS_W     = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ_OUT   = 3'd5;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_MISS  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DUMP   = 3'b100
  } state_e;

  typedef struct packed {
    logic              take;
    logic              upd;
    logic              walk_start;
    logic              step;
    logic              load;
    logic [STS_W-1:0]  sts;
    logic              with_pos;
    logic              with_data;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              match;
    logic              walk_last;
    logic              out_free;
  } stat_t;

endpackage

/* design/cldq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used by the deque datapath for the entry store.
module cldq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/cldq_ctrl.sv */
// Controller state machine of the circular deque: decodes each word and sequences walks.
// Depends on cldq_pkg; drives the datapath through cmd_t and watches it through stat_t.
module cldq_ctrl import cldq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = stat_i.out_free;
        if (s_valid_i && stat_i.out_free) begin
          cmd_o.take = 1'b1;
          unique case (stat_i.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              cmd_o.load = 1'b1;
              cmd_o.last = 1'b1;
              if (stat_i.full) begin
                cmd_o.sts = STS_FULL;
              end else begin
                cmd_o.sts = STS_OK;
                cmd_o.upd = 1'b1;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              cmd_o.load = 1'b1;
              cmd_o.last = 1'b1;
              if (stat_i.empty) begin
                cmd_o.sts = STS_EMPTY;
              end else begin
                cmd_o.sts = STS_OK;
                cmd_o.upd = 1'b1;
              end
            end
            MODE_SEARCH, MODE_READ_OUT: begin
              if (stat_i.empty) begin
                cmd_o.load = 1'b1;
                cmd_o.last = 1'b1;
                cmd_o.sts  = STS_EMPTY;
              end else begin
                cmd_o.walk_start = 1'b1;
                state_d = (stat_i.mode == MODE_SEARCH) ? S_SEARCH : S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (stat_i.match || stat_i.walk_last) begin
          if (stat_i.out_free) begin
            cmd_o.load     = 1'b1;
            cmd_o.last     = 1'b1;
            cmd_o.with_pos = stat_i.match;
            cmd_o.sts      = stat_i.match ? STS_OK : STS_MISS;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.sts       = STS_OK;
          cmd_o.with_data = 1'b1;
          cmd_o.last      = stat_i.walk_last;
          if (stat_i.walk_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* design/cldq_dp.sv */
// Datapath of the circular deque: ring pointers, entry RAM, walk cursor and output register.
// Depends on cldq_pkg and cldq_ram; acts only on commands from the controller.
module cldq_dp import cldq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic                 m_tlast_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = AW + 1;
  localparam int PFW = (CW > POS_W) ? CW : POS_W;

  logic [MODE_W-1:0]        in_mode;
  logic signed [DATA_W-1:0] in_value;

  logic [AW-1:0]            front_q, front_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] value_q;

  logic [AW-1:0]            front_inc, front_dec, ptr_inc, back_slot;
  logic [SW-1:0]            back_sum;
  logic [PFW-1:0]           pos_full;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [DATA_W-1:0]        rd_data;

  logic                     out_valid_q;
  logic [STS_W-1:0]         out_sts_q;
  logic [POS_W-1:0]         out_pos_q;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_last_q;

  assign in_mode  = s_tdata_i[MODE_W-1:0];
  assign in_value = s_tdata_i[MODE_W +: DATA_W];

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign ptr_inc   = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

  assign wr_en   = cmd_i.upd && ((in_mode == MODE_PUSH_FRONT) || (in_mode == MODE_PUSH_BACK));
  assign wr_addr = (in_mode == MODE_PUSH_FRONT) ? front_dec : back_slot;
  assign rd_en   = cmd_i.walk_start || cmd_i.step;
  assign rd_addr = cmd_i.walk_start ? front_q : ptr_inc;

  cldq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.upd) begin
      unique case (in_mode)
        MODE_PUSH_FRONT: begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
        MODE_PUSH_BACK: begin
          count_d = count_q + CW'(1);
        end
        MODE_POP_FRONT: begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
        MODE_POP_BACK: begin
          count_d = count_q - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    idx_d = idx_q;
    if (cmd_i.walk_start) begin
      ptr_d = front_q;
      idx_d = '0;
    end else if (cmd_i.step) begin
      ptr_d = ptr_inc;
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_q <= in_value;
    end
  end

  assign pos_full = PFW'(idx_q) + PFW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_sts_q  <= cmd_i.sts;
      out_pos_q  <= cmd_i.with_pos ? pos_full[POS_W-1:0] : '0;
      out_data_q <= cmd_i.with_data ? rd_data : '0;
      out_last_q <= cmd_i.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = M_TDATA_W'({out_data_q, out_pos_q, out_sts_q});

  assign stat_o.mode      = in_mode;
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.match     = (rd_data == value_q);
  assign stat_o.walk_last = (CW'(idx_q) == (count_q - CW'(1)));
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

endmodule

/* design/circular_list_deque_with_search.sv */
// Top level of the bounded circular deque with search and read out.
// Depends on cldq_pkg, cldq_ctrl, cldq_dp and cldq_ram.
//
// Usage: each word on the slave stream carries an operation code and a 32-bit value.
// Inserts and removals at either end, search and read out each answer on the master
// stream; every answer carries a status, a search position, read-out data and tlast,
// which is set on the final word caused by the request.
// Operation: an insert or a removal answers in the cycle after it is accepted. A search
// reads one stored entry per cycle from the single read port of the entry RAM, from
// the front, and answers at the first match or after the last entry when none matches.
// Read out emits one word per cycle while the receiver takes them, count words in all.
// Throughput: one request is in flight at a time; inserts and removals sustain one
// request per cycle while the receiver keeps up; a search or read out blocks new ones.
// Reset empties the deque at once; the entry RAM is not cleared and never read
// before it is written. When the receiver stalls, the output register holds its
// word, the walk pauses and s_axis_tready stays low until the word is taken.
module circular_list_deque_with_search import cldq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // s_axis_tdata: mode [2:0], value [34:3], zero fill above.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // m_axis_tdata: status [1:0], position [6:2], data_out [38:7], zero fill above.
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  cmd_t  cmd;
  stat_t stat;

  cldq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cldq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

/* design/cldq_checker.sv */
// Port-level checker of the circular deque, bound to the top level.
// Depends on cldq_pkg and the assertion macros in circular_list_deque_with_search_assert.svh.
`include "circular_list_deque_with_search_assert.svh"

module cldq_checker import cldq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready
);

  logic [STS_W-1:0]  sts;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] dout;
  logic              hold;

  assign sts  = m_axis_tdata[STS_W-1:0];
  assign pos  = m_axis_tdata[STS_W +: POS_W];
  assign dout = m_axis_tdata[STS_W + POS_W +: DATA_W];
  assign hold = m_axis_tvalid && !m_axis_tready;

  `CLDQ_ASSERT_NEXT(a_valid_holds, hold, m_axis_tvalid, "Output word dropped while stalled.")
  `CLDQ_ASSERT_NEXT(a_word_holds, hold, $stable(m_axis_tdata) && $stable(m_axis_tlast),
                    "Output word changed while stalled.")
  `CLDQ_ASSERT_NOW(a_error_is_last, m_axis_tvalid && (sts != STS_OK), m_axis_tlast,
                   "An error status must end the answer.")
  `CLDQ_ASSERT_NOW(a_pos_only_ok, m_axis_tvalid && (pos != '0),
                   (sts == STS_OK) && m_axis_tlast && (dout == '0),
                   "A search position appeared outside a single successful answer.")
  `CLDQ_ASSERT_NOW(a_data_only_ok, m_axis_tvalid && (dout != '0),
                   (sts == STS_OK) && (pos == '0),
                   "Read-out data appeared outside a successful read out.")

endmodule

bind circular_list_deque_with_search cldq_checker u_cldq_checker (.*);
